// ----- src/tspool_pkg.sv -----
// Package for the timed slot pool: shared types, codes and constants.
// Used by tspool_ctrl, tspool_dp and timed_slot_pool_oldest_replace.
package tspool_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int MAX_OUT = 8;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [2:0] KIND_LIVE    = 3'd0;
   localparam logic [2:0] KIND_EMPTY   = 3'd1;
   localparam logic [2:0] KIND_ADDFREE = 3'd2;
   localparam logic [2:0] KIND_ADDREPL = 3'd3;
   localparam logic [2:0] KIND_CLEARED = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TSCAN,
      ST_TEMIT,
      ST_TNONE,
      ST_ASCAN,
      ST_ADIV,
      ST_AWRITE,
      ST_ARESP,
      ST_CLEAR
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // capture request, advance clock on tick
      logic scan_clr;   // reset scan index and search state
      logic scan_step;  // examine one slot
      logic div_start;
      logic write_ent;
      logic clear_all;
      logic emit_live;  // find next survivor and emit it
      logic emit_none;
      logic emit_add;
      logic emit_clear;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic emit_done;  // no survivor beyond the one being emitted, or output cap reached
      logic any_live;
   } sts_type;

endpackage

// ----- src/timed_slot_pool_oldest_replace.sv -----
// Top level of the timed slot pool with oldest-entry replacement.
// Depends on tspool_pkg, tspool_ctrl and tspool_dp.
//
// A request beat is taken when start is high and busy is low; req_action
// selects tick (0), add (1) or clear (2); code 3 is taken and dropped silently.
// Results leave as beats marked by rsp_valid, one cycle each; the
// receiver cannot stall them. rsp_last flags the final beat of a request.
// A tick scans one slot a cycle over all SLOTS slots; its survivor beats
// then follow back to back, at most eight, or a single empty beat comes
// when none are live. An add scans every slot for a free or oldest slot,
// then runs a one-bit-per-cycle divider of 28 steps for the spread rate
// and writes the slot before its beat goes out; the divider is skipped
// for a zero duration. A clear empties the pool and puts its single beat
// out from the result register. busy falls in the cycle that carries the
// last beat, so the next request can be taken at the edge that ends it.
// Reset frees every slot and zeroes the clock and the insertion stamp
// counter.
module timed_slot_pool_oldest_replace #(
   parameter int SLOTS = tspool_pkg::SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_action,
   input  logic [15:0]          req_time_step,
   input  logic signed [15:0]   req_center_x,
   input  logic signed [15:0]   req_center_z,
   input  logic [15:0]          req_life_span,
   input  logic [15:0]          req_strength,
   input  logic [15:0]          req_reach,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_kind,
   output logic [2:0]           rsp_slot,
   output logic signed [15:0]   rsp_pos_x,
   output logic signed [15:0]   rsp_pos_z,
   output logic [31:0]          rsp_born_at,
   output logic [15:0]          rsp_power,
   output logic [15:0]          rsp_lifetime,
   output logic [15:0]          rsp_radius_max,
   output logic [31:0]          rsp_spread_rate,
   output logic [31:0]          rsp_clock_now,
   output logic [3:0]           rsp_live_count,
   output logic                 rsp_last
);
   import tspool_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   action_type act;

   assign act = action_type'(req_action);

   tspool_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (act),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   tspool_dp #(.SLOTS(SLOTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (act),
      .req_time_step   (req_time_step),
      .req_center_x    (req_center_x),
      .req_center_z    (req_center_z),
      .req_life_span   (req_life_span),
      .req_strength    (req_strength),
      .req_reach       (req_reach),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_slot),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_born_at     (rsp_born_at),
      .rsp_power       (rsp_power),
      .rsp_lifetime    (rsp_lifetime),
      .rsp_radius_max  (rsp_radius_max),
      .rsp_spread_rate (rsp_spread_rate),
      .rsp_clock_now   (rsp_clock_now),
      .rsp_live_count  (rsp_live_count),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- src/tspool_ctrl.sv -----
// Controller state machine of the timed slot pool.
// Depends on tspool_pkg for the state, command and status types.
module tspool_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tspool_pkg::action_type action,
   input  tspool_pkg::sts_type   sts,
   output tspool_pkg::cmd_type   cmd,
   output logic                  busy
);
   import tspool_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cmd.scan_clr = 1'b1;
               case (action)
                  ACT_TICK:  state_in = ST_TSCAN;
                  ACT_ADD:   state_in = ST_ASCAN;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_TSCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_TEMIT;
            end
         end
         ST_TEMIT: begin
            if (!sts.any_live) begin
               state_in = ST_TNONE;
            end else begin
               cmd.emit_live = 1'b1;
               if (sts.emit_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TNONE: begin
            cmd.emit_none = 1'b1;
            state_in = ST_IDLE;
         end
         ST_ASCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               cmd.div_start = 1'b1;
               state_in = ST_ADIV;
            end
         end
         ST_ADIV: begin
            if (sts.div_done) begin
               state_in = ST_AWRITE;
            end
         end
         ST_AWRITE: begin
            cmd.write_ent = 1'b1;
            state_in = ST_ARESP;
         end
         ST_ARESP: begin
            cmd.emit_add = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clear_all = 1'b1;
            cmd.emit_clear = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_idle_no_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy) else $error("busy while idle");
   a_write_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.write_ent |=> cmd.emit_add) else $error("add result not emitted");
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && action != ACT_NONE) |=> busy) else $error("start lost");

endmodule

// ----- src/tspool_dp.sv -----
// Datapath of the timed slot pool: slot store, scan, serial divider and result register.
// Depends on tspool_pkg for command, status and result codes.
module tspool_dp #(
   parameter int SLOTS = tspool_pkg::SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tspool_pkg::cmd_type  cmd,
   output tspool_pkg::sts_type  sts,
   input  tspool_pkg::action_type req_action,
   input  logic [15:0]          req_time_step,
   input  logic signed [15:0]   req_center_x,
   input  logic signed [15:0]   req_center_z,
   input  logic [15:0]          req_life_span,
   input  logic [15:0]          req_strength,
   input  logic [15:0]          req_reach,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_kind,
   output logic [2:0]           rsp_slot,
   output logic signed [15:0]   rsp_pos_x,
   output logic signed [15:0]   rsp_pos_z,
   output logic [31:0]          rsp_born_at,
   output logic [15:0]          rsp_power,
   output logic [15:0]          rsp_lifetime,
   output logic [15:0]          rsp_radius_max,
   output logic [31:0]          rsp_spread_rate,
   output logic [31:0]          rsp_clock_now,
   output logic [3:0]           rsp_live_count,
   output logic                 rsp_last
);
   import tspool_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [SLOTS-1:0]  busy_ff, busy_in;
   logic [15:0]       ent_x_ff     [SLOTS];
   logic [15:0]       ent_z_ff     [SLOTS];
   logic [31:0]       ent_start_ff [SLOTS];
   logic [15:0]       ent_power_ff [SLOTS];
   logic [15:0]       ent_life_ff  [SLOTS];
   logic [15:0]       ent_reach_ff [SLOTS];
   logic [31:0]       ent_rate_ff  [SLOTS];
   logic [31:0]       ent_stamp_ff [SLOTS];
   logic [31:0]       clock_ff;
   logic [31:0]       stamp_next_ff;

   action_type        act_ff;
   logic [15:0]       x_ff, z_ff, life_ff, power_ff, reach_ff;
   logic [IW:0]       idx_ff;
   logic [IW-1:0]     free_ff, old_ff;
   logic              found_free_ff;
   logic [31:0]       low_ff;
   logic [CW-1:0]     live_ff;
   logic [SLOTS-1:0]  pend_ff;
   logic [3:0]        emit_cnt_ff;

   // Divider: 28-bit dividend, restoring, one bit a cycle.
   logic [27:0]       dq_ff;
   logic [16:0]       rem_ff;
   logic [4:0]        dcnt_ff;
   logic              drun_ff;
   logic [16:0]       rtrial;

   logic [IW-1:0]     cur;
   logic [31:0]       elapsed;
   logic [IW-1:0]     tgt;
   logic [IW-1:0]     nxt;
   logic              nxt_more;
   logic [SLOTS-1:0]  pend_clr;

   assign cur = idx_ff[IW-1:0];
   assign elapsed = clock_ff - ent_start_ff[cur];
   assign tgt = found_free_ff ? free_ff : old_ff;

   // Lowest pending survivor and whether another follows.
   always_comb begin
      nxt = '0;
      nxt_more = 1'b0;
      pend_clr = pend_ff;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            nxt = IW'(i);
         end
      end
      pend_clr[nxt] = 1'b0;
      nxt_more = |pend_clr;
   end

   assign sts.scan_done = (idx_ff == (IW+1)'(SLOTS - 1));
   assign sts.div_done = !drun_ff;
   assign sts.any_live = |pend_ff;
   assign sts.emit_done = !nxt_more || (emit_cnt_ff == 4'(MAX_OUT - 1));

   always_comb begin
      busy_in = busy_ff;
      if (cmd.scan_step && act_ff == ACT_TICK && busy_ff[cur] &&
          elapsed > {16'd0, ent_life_ff[cur]}) begin
         busy_in[cur] = 1'b0;
      end
      if (cmd.write_ent) begin
         busy_in[tgt] = 1'b1;
      end
      if (cmd.clear_all) begin
         busy_in = '0;
      end
   end

   assign rtrial = {rem_ff[15:0], dq_ff[27]} - {1'b0, life_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         clock_ff <= '0;
         stamp_next_ff <= '0;
         drun_ff <= 1'b0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            ent_stamp_ff[i] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         rsp_valid <= cmd.emit_live | cmd.emit_none | cmd.emit_add | cmd.emit_clear;
         if (cmd.load && req_action == ACT_TICK) begin
            clock_ff <= clock_ff + {16'd0, req_time_step};
         end
         if (cmd.div_start) begin
            drun_ff <= (life_ff != 16'd0);
         end else if (drun_ff && dcnt_ff == 5'd27) begin
            drun_ff <= 1'b0;
         end
         if (cmd.write_ent) begin
            ent_stamp_ff[tgt] <= stamp_next_ff;
            stamp_next_ff <= stamp_next_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         x_ff <= req_center_x;
         z_ff <= req_center_z;
         life_ff <= req_life_span;
         power_ff <= req_strength;
         reach_ff <= req_reach;
      end
      if (cmd.scan_clr) begin
         idx_ff <= '0;
         found_free_ff <= 1'b0;
         free_ff <= '0;
         old_ff <= '0;
         low_ff <= ent_stamp_ff[0];
         live_ff <= '0;
         pend_ff <= '0;
         emit_cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (busy_ff[cur] && elapsed <= {16'd0, ent_life_ff[cur]}) begin
            pend_ff[cur] <= 1'b1;
            live_ff <= live_ff + 1'b1;
         end
         if (!busy_ff[cur] && !found_free_ff) begin
            found_free_ff <= 1'b1;
            free_ff <= cur;
         end
         if (ent_stamp_ff[cur] < low_ff) begin
            low_ff <= ent_stamp_ff[cur];
            old_ff <= cur;
         end
      end else if (cmd.emit_live) begin
         pend_ff[nxt] <= 1'b0;
         emit_cnt_ff <= emit_cnt_ff + 4'd1;
      end
      if (cmd.div_start) begin
         dq_ff <= {reach_ff, 12'd0};
         rem_ff <= '0;
         dcnt_ff <= '0;
      end else if (drun_ff) begin
         dcnt_ff <= dcnt_ff + 5'd1;
         if (!rtrial[16]) begin
            rem_ff <= rtrial;
            dq_ff <= {dq_ff[26:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[15:0], dq_ff[27]};
            dq_ff <= {dq_ff[26:0], 1'b0};
         end
      end
      if (cmd.write_ent) begin
         ent_x_ff[tgt] <= x_ff;
         ent_z_ff[tgt] <= z_ff;
         ent_start_ff[tgt] <= clock_ff;
         ent_power_ff[tgt] <= power_ff;
         ent_life_ff[tgt] <= life_ff;
         ent_reach_ff[tgt] <= reach_ff;
         ent_rate_ff[tgt] <= (life_ff == 16'd0) ? 32'hFFFF_FFFF : {4'd0, dq_ff};
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind <= KIND_LIVE;
      rsp_slot <= '0;
      rsp_pos_x <= '0;
      rsp_pos_z <= '0;
      rsp_born_at <= '0;
      rsp_power <= '0;
      rsp_lifetime <= '0;
      rsp_radius_max <= '0;
      rsp_spread_rate <= '0;
      rsp_clock_now <= clock_ff;
      rsp_live_count <= 4'(live_ff);
      rsp_last <= 1'b1;
      if (cmd.emit_live || cmd.emit_add) begin
         rsp_slot <= 3'(cmd.emit_live ? nxt : tgt);
         rsp_pos_x <= ent_x_ff[cmd.emit_live ? nxt : tgt];
         rsp_pos_z <= ent_z_ff[cmd.emit_live ? nxt : tgt];
         rsp_born_at <= ent_start_ff[cmd.emit_live ? nxt : tgt];
         rsp_power <= ent_power_ff[cmd.emit_live ? nxt : tgt];
         rsp_lifetime <= ent_life_ff[cmd.emit_live ? nxt : tgt];
         rsp_radius_max <= ent_reach_ff[cmd.emit_live ? nxt : tgt];
         rsp_spread_rate <= ent_rate_ff[cmd.emit_live ? nxt : tgt];
      end
      if (cmd.emit_live) begin
         rsp_last <= sts.emit_done;
      end
      if (cmd.emit_none) begin
         rsp_kind <= KIND_EMPTY;
      end
      if (cmd.emit_add) begin
         rsp_kind <= found_free_ff ? KIND_ADDFREE : KIND_ADDREPL;
         rsp_live_count <= 4'($countones(busy_ff));
      end
      if (cmd.emit_clear) begin
         rsp_kind <= KIND_CLEARED;
         rsp_live_count <= '0;
      end
   end

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_live, cmd.emit_none, cmd.emit_add, cmd.emit_clear}))
      else $error("two emits at once");
   a_write_sets_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.write_ent |=> busy_ff[$past(tgt)]) else $error("written slot not busy");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> busy_ff == '0) else $error("clear left slots busy");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the timed slot pool with oldest-entry replacement.
// Depends on tspool_pkg and timed_slot_pool_oldest_replace; drives directed and random beats.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tspool_pkg::*;

   localparam int NSLOT = 8;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  slot;
      logic [15:0] pos_x;
      logic [15:0] pos_z;
      logic [31:0] born_at;
      logic [15:0] power;
      logic [15:0] lifetime;
      logic [15:0] radius_max;
      logic [31:0] spread_rate;
      logic [31:0] clock_now;
      logic [3:0]  live_count;
      logic        last;
   } beat_type;

   typedef struct {
      logic [1:0]  act;
      logic [15:0] step, cx, cz, life, str, rch;
      logic        has_exp;
      beat_type    exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = '0;
   logic [15:0] req_time_step = '0, req_life_span = '0, req_strength = '0, req_reach = '0;
   logic signed [15:0] req_center_x = '0, req_center_z = '0;
   logic rsp_valid, rsp_last;
   logic [2:0] rsp_kind, rsp_slot;
   logic signed [15:0] rsp_pos_x, rsp_pos_z;
   logic [31:0] rsp_born_at, rsp_spread_rate, rsp_clock_now;
   logic [15:0] rsp_power, rsp_lifetime, rsp_radius_max;
   logic [3:0] rsp_live_count;

   timed_slot_pool_oldest_replace dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Model state of the pool.
   logic        pool_busy [NSLOT];
   beat_type    pool_ent [NSLOT];
   logic [31:0] pool_stamp [NSLOT];
   logic [31:0] pool_clock, pool_stamp_next;

   beat_type pending_beats [$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   function automatic beat_type blank_beat(logic [2:0] k, logic [3:0] n);
      beat_type b;
      b = '0;
      b.kind = k;
      b.clock_now = pool_clock;
      b.live_count = n;
      b.last = 1'b1;
      return b;
   endfunction

   task automatic predict_pool(input row_type r);
      int found [$];
      int tgt;
      int n;
      logic [31:0] lowest;
      beat_type b;
      case (action_type'(r.act))
         ACT_TICK: begin
            pool_clock = pool_clock + r.step;
            for (int i = 0; i < NSLOT; i++)
               if (pool_busy[i]) begin
                  if (pool_clock - pool_ent[i].born_at > {16'd0, pool_ent[i].lifetime})
                     pool_busy[i] = 1'b0;
                  else
                     found.push_back(i);
               end
            if (found.size() == 0)
               pending_beats.push_back(blank_beat(KIND_EMPTY, 4'd0));
            else
               for (int k = 0; k < found.size() && k < MAX_OUT; k++) begin
                  b = pool_ent[found[k]];
                  b.kind = KIND_LIVE;
                  b.clock_now = pool_clock;
                  b.live_count = 4'(found.size());
                  b.last = (k + 1 == found.size()) || (k + 1 == MAX_OUT);
                  pending_beats.push_back(b);
               end
         end
         ACT_ADD: begin
            tgt = -1;
            b = '0;
            b.kind = KIND_ADDFREE;
            for (int i = NSLOT - 1; i >= 0; i--)
               if (!pool_busy[i]) tgt = i;
            if (tgt < 0) begin
               b.kind = KIND_ADDREPL;
               tgt = 0;
               lowest = pool_stamp[0];
               for (int i = 1; i < NSLOT; i++)
                  if (pool_stamp[i] < lowest) begin
                     lowest = pool_stamp[i];
                     tgt = i;
                  end
            end
            b.slot = 3'(tgt);
            b.pos_x = r.cx;
            b.pos_z = r.cz;
            b.born_at = pool_clock;
            b.power = r.str;
            b.lifetime = r.life;
            b.radius_max = r.rch;
            b.spread_rate = (r.life == 0) ? 32'hFFFF_FFFF
                          : 32'(({16'd0, r.rch} << 12) / {16'd0, r.life});
            pool_ent[tgt] = b;
            pool_stamp[tgt] = pool_stamp_next;
            pool_stamp_next = pool_stamp_next + 1;
            pool_busy[tgt] = 1'b1;
            n = 0;
            foreach (pool_busy[i]) n += pool_busy[i];
            b.clock_now = pool_clock;
            b.live_count = 4'(n);
            b.last = 1'b1;
            pending_beats.push_back(b);
         end
         ACT_CLEAR: begin
            foreach (pool_busy[i]) pool_busy[i] = 1'b0;
            pending_beats.push_back(blank_beat(KIND_CLEARED, 4'd0));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      beat_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_kind, rsp_slot, rsp_pos_x, rsp_pos_z, rsp_born_at, rsp_power,
                 rsp_lifetime, rsp_radius_max, rsp_spread_rate, rsp_clock_now,
                 rsp_live_count, rsp_last};
         if (pending_beats.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected beat %h", got);
         end else begin
            want = pending_beats.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("Mismatch: expected %h, got %h", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_beat(input row_type r);
      while ($urandom_range(99) < send_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= r.act;
      req_time_step <= r.step;
      req_center_x <= r.cx;
      req_center_z <= r.cz;
      req_life_span <= r.life;
      req_strength <= r.str;
      req_reach <= r.rch;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.has_exp) begin
         predict_pool(r);
         pending_beats.pop_back();
         pending_beats.push_back(r.exp);
      end else
         predict_pool(r);
   endtask

   function automatic row_type mk(logic [1:0] a, logic [15:0] st, logic [15:0] x,
                                  logic [15:0] z, logic [15:0] l, logic [15:0] s,
                                  logic [15:0] c);
      row_type r;
      r.act = a; r.step = st; r.cx = x; r.cz = z; r.life = l; r.str = s; r.rch = c;
      r.has_exp = 1'b0;
      r.exp = '0;
      return r;
   endfunction

   function automatic row_type rand_row();
      row_type r;
      int p;
      p = $urandom_range(99);
      r = mk(ACT_ADD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom));
      if (p < 45) r.act = ACT_TICK;
      else if (p < 92) r.act = ACT_ADD;
      else if (p < 97) r.act = ACT_CLEAR;
      else r.act = ACT_NONE;
      if ($urandom_range(3) != 0) r.step = 16'($urandom_range(300));
      if ($urandom_range(3) != 0) r.life = 16'($urandom_range(2000));
      if ($urandom_range(15) == 0) r.life = 16'd0;
      return r;
   endfunction

   row_type directed [$];

   initial begin
      row_type r;
      foreach (pool_busy[i]) begin
         pool_busy[i] = 1'b0;
         pool_ent[i] = '0;
         pool_stamp[i] = '0;
      end
      pool_clock = '0;
      pool_stamp_next = '0;

      // Tick after reset: nothing live.
      r = mk(ACT_TICK, 16'd0, 0, 0, 0, 0, 0);
      r.has_exp = 1'b1; r.exp = '0; r.exp.kind = KIND_EMPTY; r.exp.last = 1'b1;
      directed.push_back(r);
      // Add with extremes, zero duration saturates the rate.
      r = mk(ACT_ADD, 0, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'hFFFF);
      r.has_exp = 1'b1;
      r.exp = '{KIND_ADDFREE, 3'd0, 16'h8000, 16'h7FFF, 32'd0, 16'hFFFF, 16'd0,
                16'hFFFF, 32'hFFFF_FFFF, 32'd0, 4'd1, 1'b1};
      directed.push_back(r);
      directed.push_back(mk(ACT_ADD, 0, 16'h7FFF, 16'h8000, 16'hFFFF, 0, 16'hFFFF));
      directed.push_back(mk(ACT_ADD, 0, 16'hFFFF, 0, 16'd1, 16'h0100, 16'd0));
      for (int i = 0; i < 5; i++)
         directed.push_back(mk(ACT_ADD, 0, 16'(i * 77), 16'(-i), 16'(100 + i), 16'(i),
                               16'(i * 999)));
      // The pool is full: these replace the oldest entries.
      directed.push_back(mk(ACT_ADD, 0, 16'h1234, 16'h4321, 16'd500, 16'd9, 16'd40));
      directed.push_back(mk(ACT_ADD, 0, 16'h0F0F, 16'hF0F0, 16'd1, 16'd9, 16'd1));
      directed.push_back(mk(ACT_TICK, 16'd1, 0, 0, 0, 0, 0));
      directed.push_back(mk(ACT_TICK, 16'd100, 0, 0, 0, 0, 0));
      directed.push_back(mk(ACT_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF));
      directed.push_back(mk(ACT_TICK, 16'hFFFF, 0, 0, 0, 0, 0));
      r = mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
      r.has_exp = 1'b1; r.exp = '0; r.exp.kind = KIND_CLEARED; r.exp.last = 1'b1;
      r.exp.clock_now = 32'h0001_0064;
      directed.push_back(r);
      directed.push_back(mk(ACT_TICK, 16'd5, 0, 0, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_beat(directed[i]);
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1) ? 85 : (ph == 3) ? 37 : 0;
         for (int n = 0; n < 110; n++) send_beat(rand_row());
      end
      start <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (3 * NSLOT + 40) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
src/tspool_pkg.sv
src/tspool_ctrl.sv
src/tspool_dp.sv
src/timed_slot_pool_oldest_replace.sv
test/tb_top.sv
